// ===== hw/rtl/abs_pkg.sv =====
`default_nettype none

package abs_pkg;

  localparam int unsigned DelayWidth = 16;
  localparam int unsigned CfgIndexWidth = 3;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_PRIORITY = 3'd1,
    ST_CHANGE   = 3'd2,
    ST_RELEASE  = 3'd3,
    ST_WAIT     = 3'd4,
    ST_BACK     = 3'd5,
    ST_END      = 3'd6
  } seq_state_t;

  localparam logic [1:0] CH_FRONT = 2'd0;
  localparam logic [1:0] CH_PHONE = 2'd1;
  localparam logic [1:0] CH_NAVI  = 2'd2;

  localparam logic [CfgIndexWidth-1:0] CFG_PHONE_ENTRY  = 3'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_NAVI_ENTRY   = 3'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_PHONE_SWITCH = 3'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_NAVI_SWITCH  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] CFG_EXIT         = 3'd4;

  localparam logic [DelayWidth-1:0] PHONE_ENTRY_RESET  = 16'd300;
  localparam logic [DelayWidth-1:0] NAVI_ENTRY_RESET   = 16'd3;
  localparam logic [DelayWidth-1:0] PHONE_SWITCH_RESET = 16'd5;
  localparam logic [DelayWidth-1:0] NAVI_SWITCH_RESET  = 16'd2;
  localparam logic [DelayWidth-1:0] EXIT_RESET         = 16'd5;

  typedef struct packed {
    logic [DelayWidth-1:0] phone_entry_delay;
    logic [DelayWidth-1:0] navi_entry_delay;
    logic [DelayWidth-1:0] phone_switch_delay;
    logic [DelayWidth-1:0] navi_switch_delay;
    logic [DelayWidth-1:0] exit_delay;
  } abs_cfg_t;

  typedef struct packed {
    seq_state_t            seq_state;
    logic [DelayWidth-1:0] delay_count;
    logic                  phone_active;
    logic                  navi_active;
  } abs_ctx_t;

  typedef struct packed {
    logic       mute_request;
    logic       channel_valid;
    logic [1:0] channel_select;
    logic       clear_system_mute;
    logic       mark_unmuted;
    logic       post_setup;
    logic       clear_gates;
  } abs_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/audio_breakin_sequencer.sv =====
// Audio break-in sequencer: each input transfer is one scheduler tick and yields exactly
// one result transfer. A tick can be taken every clock cycle while in_stall is low;
// its result appears in the output register in the next cycle, and in_stall rises
// only while that register holds a result that the receiver is stalling. The step
// itself is one pass through the sequencing logic on the stored state. Configuration
// writes are always ready; indexes beyond the exit delay are ignored.
`default_nettype none

module audio_breakin_sequencer (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire                                      power_on,
  input  wire                                      system_muted,
  input  wire                                      phone_gate,
  input  wire                                      navi_gate,
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic                                     mute_request,
  output logic                                     channel_valid,
  output logic [1:0]                               channel_select,
  output logic                                     clear_system_mute,
  output logic                                     mark_unmuted,
  output logic                                     post_setup,
  output logic                                     clear_gates,
  output logic [2:0]                               sequence_state,
  input  wire                                      cfg_valid,
  output logic                                     cfg_ready,
  input  wire  [abs_pkg::CfgIndexWidth-1:0]        cfg_index,
  input  wire  [abs_pkg::DelayWidth-1:0]           cfg_data
);
  import abs_pkg::*;

  abs_cfg_t cfg;
  abs_ctx_t ctx;
  abs_ctx_t ctx_next;
  abs_res_t res_next;
  logic     in_accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phone_entry_delay  <= PHONE_ENTRY_RESET;
      cfg.navi_entry_delay   <= NAVI_ENTRY_RESET;
      cfg.phone_switch_delay <= PHONE_SWITCH_RESET;
      cfg.navi_switch_delay  <= NAVI_SWITCH_RESET;
      cfg.exit_delay         <= EXIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PHONE_ENTRY:  cfg.phone_entry_delay  <= cfg_data;
        CFG_NAVI_ENTRY:   cfg.navi_entry_delay   <= cfg_data;
        CFG_PHONE_SWITCH: cfg.phone_switch_delay <= cfg_data;
        CFG_NAVI_SWITCH:  cfg.navi_switch_delay  <= cfg_data;
        CFG_EXIT:         cfg.exit_delay         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  abs_step u_step (
    .cfg          (cfg),
    .ctx          (ctx),
    .power_on     (power_on),
    .system_muted (system_muted),
    .phone_gate   (phone_gate),
    .navi_gate    (navi_gate),
    .ctx_next     (ctx_next),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.seq_state    <= ST_IDLE;
      ctx.delay_count  <= '0;
      ctx.phone_active <= 1'b0;
      ctx.navi_active  <= 1'b0;
    end else if (in_accept) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mute_request      <= res_next.mute_request;
      channel_valid     <= res_next.channel_valid;
      channel_select    <= res_next.channel_select;
      clear_system_mute <= res_next.clear_system_mute;
      mark_unmuted      <= res_next.mark_unmuted;
      post_setup        <= res_next.post_setup;
      clear_gates       <= res_next.clear_gates;
      sequence_state    <= ctx_next.seq_state;
    end
  end

  a_power_off_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && !power_on |=> ctx.seq_state == ST_IDLE && clear_gates)
    else $error("power off did not return sequence to idle");

  a_countdown: assert property (@(posedge clk) disable iff (rst)
    in_accept && power_on && ctx.delay_count != '0
      |=> ctx.delay_count == $past(ctx.delay_count) - 1'b1 && !mute_request)
    else $error("delay count did not step down");

  a_front_when_no_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && !channel_valid |-> channel_select == CH_FRONT)
    else $error("channel select set without a switch");

  a_setup_enters_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && post_setup |-> sequence_state == ST_WAIT && mark_unmuted)
    else $error("setup notice outside release step");

endmodule

`default_nettype wire

// ===== hw/rtl/abs_step.sv =====
`default_nettype none

module abs_step (
  input  wire abs_pkg::abs_cfg_t cfg,
  input  wire abs_pkg::abs_ctx_t ctx,
  input  wire                    power_on,
  input  wire                    system_muted,
  input  wire                    phone_gate,
  input  wire                    navi_gate,
  output abs_pkg::abs_ctx_t      ctx_next,
  output abs_pkg::abs_res_t      res
);
  import abs_pkg::*;

  logic counting;

  assign counting = (ctx.delay_count != '0);

  // next state
  always_comb begin
    ctx_next = ctx;
    if (!power_on) begin
      ctx_next.seq_state = ST_IDLE;
    end else if (counting) begin
      ctx_next.delay_count = ctx.delay_count - 1'b1;
    end else begin
      unique case (ctx.seq_state)
        ST_IDLE: begin
          if (!system_muted && (navi_gate || phone_gate)) begin
            ctx_next.seq_state = ST_PRIORITY;
          end
        end
        ST_PRIORITY: begin
          if (phone_gate) begin
            ctx_next.delay_count  = cfg.phone_entry_delay;
            ctx_next.phone_active = 1'b1;
          end else if (navi_gate) begin
            ctx_next.delay_count = cfg.navi_entry_delay;
            ctx_next.navi_active = 1'b1;
          end
          ctx_next.seq_state = ST_CHANGE;
        end
        ST_CHANGE: begin
          if (ctx.phone_active) begin
            ctx_next.delay_count = cfg.phone_switch_delay;
          end else if (ctx.navi_active) begin
            ctx_next.delay_count = cfg.navi_switch_delay;
          end
          ctx_next.seq_state = ST_RELEASE;
        end
        ST_RELEASE: begin
          ctx_next.seq_state = ST_WAIT;
        end
        ST_WAIT: begin
          if (!phone_gate && ctx.phone_active) begin
            ctx_next.delay_count  = cfg.exit_delay;
            ctx_next.phone_active = 1'b0;
            ctx_next.seq_state    = ST_BACK;
          end else if (!navi_gate && ctx.navi_active) begin
            ctx_next.delay_count = cfg.exit_delay;
            ctx_next.navi_active = 1'b0;
            ctx_next.seq_state   = ST_BACK;
          end
        end
        ST_BACK: begin
          ctx_next.delay_count = cfg.exit_delay;
          ctx_next.seq_state   = ST_END;
        end
        ST_END: begin
          ctx_next.seq_state = ST_IDLE;
        end
        default: begin
          ctx_next = ctx;
        end
      endcase
    end
  end

  // result flags
  always_comb begin
    res = '0;
    res.channel_select = CH_FRONT;
    if (!power_on) begin
      res.clear_gates = 1'b1;
    end else if (!counting) begin
      unique case (ctx.seq_state)
        ST_PRIORITY: begin
          res.mute_request = 1'b1;
        end
        ST_CHANGE: begin
          if (ctx.phone_active) begin
            res.channel_valid  = 1'b1;
            res.channel_select = CH_PHONE;
          end else if (ctx.navi_active) begin
            res.channel_valid  = 1'b1;
            res.channel_select = CH_NAVI;
          end
        end
        ST_RELEASE: begin
          res.clear_system_mute = 1'b1;
          res.mark_unmuted      = 1'b1;
          res.post_setup        = 1'b1;
        end
        ST_WAIT: begin
          res.mute_request = (!phone_gate && ctx.phone_active) ||
                             (!navi_gate && ctx.navi_active);
        end
        ST_BACK: begin
          res.channel_valid  = 1'b1;
          res.channel_select = CH_FRONT;
        end
        ST_END: begin
          res.mark_unmuted = 1'b1;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/breakin_monitor.sv =====
module breakin_monitor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              power_on,
  input  logic                              system_muted,
  input  logic                              phone_gate,
  input  logic                              navi_gate,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              mute_request,
  input  logic                              channel_valid,
  input  logic [1:0]                        channel_select,
  input  logic                              clear_system_mute,
  input  logic                              mark_unmuted,
  input  logic                              post_setup,
  input  logic                              clear_gates,
  input  logic [2:0]                        sequence_state,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [abs_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [abs_pkg::DelayWidth-1:0]    cfg_data,
  output int                                results_owed,
  output int                                mismatch_total
);

  timeunit 1ns;
  timeprecision 1ps;

  import abs_pkg::*;

  typedef struct packed {
    abs_res_t   flags;
    seq_state_t state_after;
  } tick_result_t;

  abs_cfg_t              delays;
  seq_state_t            cur_state;
  logic [DelayWidth-1:0] hold_count;
  logic                  phone_live;
  logic                  navi_live;

  tick_result_t          awaited_results[$];
  tick_result_t          got;
  tick_result_t          want;
  int                    errors;

  function automatic tick_result_t predict_tick(input logic pwr, input logic smute,
                                                input logic ph, input logic nv);
    tick_result_t r;
    r = '0;
    if (!pwr) begin
      cur_state = ST_IDLE;
      r.flags.clear_gates = 1'b1;
    end else if (hold_count != '0) begin
      hold_count = hold_count - 1'b1;
    end else begin
      case (cur_state)
        ST_IDLE: begin
          if (!smute && (nv || ph)) cur_state = ST_PRIORITY;
        end
        ST_PRIORITY: begin
          r.flags.mute_request = 1'b1;
          if (ph) begin
            hold_count = delays.phone_entry_delay;
            phone_live = 1'b1;
          end else if (nv) begin
            hold_count = delays.navi_entry_delay;
            navi_live = 1'b1;
          end
          cur_state = ST_CHANGE;
        end
        ST_CHANGE: begin
          if (phone_live) begin
            r.flags.channel_valid = 1'b1;
            r.flags.channel_select = CH_PHONE;
            hold_count = delays.phone_switch_delay;
          end else if (navi_live) begin
            r.flags.channel_valid = 1'b1;
            r.flags.channel_select = CH_NAVI;
            hold_count = delays.navi_switch_delay;
          end
          cur_state = ST_RELEASE;
        end
        ST_RELEASE: begin
          r.flags.clear_system_mute = 1'b1;
          r.flags.mark_unmuted = 1'b1;
          r.flags.post_setup = 1'b1;
          cur_state = ST_WAIT;
        end
        ST_WAIT: begin
          if (!ph && phone_live) begin
            r.flags.mute_request = 1'b1;
            hold_count = delays.exit_delay;
            phone_live = 1'b0;
            cur_state = ST_BACK;
          end else if (!nv && navi_live) begin
            r.flags.mute_request = 1'b1;
            hold_count = delays.exit_delay;
            navi_live = 1'b0;
            cur_state = ST_BACK;
          end
        end
        ST_BACK: begin
          r.flags.channel_valid = 1'b1;
          r.flags.channel_select = CH_FRONT;
          hold_count = delays.exit_delay;
          cur_state = ST_END;
        end
        ST_END: begin
          r.flags.mark_unmuted = 1'b1;
          cur_state = ST_IDLE;
        end
        default: begin
        end
      endcase
    end
    r.state_after = cur_state;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      delays.phone_entry_delay = PHONE_ENTRY_RESET;
      delays.navi_entry_delay = NAVI_ENTRY_RESET;
      delays.phone_switch_delay = PHONE_SWITCH_RESET;
      delays.navi_switch_delay = NAVI_SWITCH_RESET;
      delays.exit_delay = EXIT_RESET;
      cur_state = ST_IDLE;
      hold_count = '0;
      phone_live = 1'b0;
      navi_live = 1'b0;
      awaited_results.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHONE_ENTRY:  delays.phone_entry_delay = cfg_data;
          CFG_NAVI_ENTRY:   delays.navi_entry_delay = cfg_data;
          CFG_PHONE_SWITCH: delays.phone_switch_delay = cfg_data;
          CFG_NAVI_SWITCH:  delays.navi_switch_delay = cfg_data;
          CFG_EXIT:         delays.exit_delay = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(predict_tick(power_on, system_muted, phone_gate, navi_gate));
      end
      if (out_valid && !out_stall) begin
        got.flags.mute_request = mute_request;
        got.flags.channel_valid = channel_valid;
        got.flags.channel_select = channel_select;
        got.flags.clear_system_mute = clear_system_mute;
        got.flags.mark_unmuted = mark_unmuted;
        got.flags.post_setup = post_setup;
        got.flags.clear_gates = clear_gates;
        got.state_after = seq_state_t'(sequence_state);
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result transfer with no tick outstanding", $time);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch (expected/actual) mute %b/%b chan %b:%0d/%b:%0d",
                       $time, want.flags.mute_request, got.flags.mute_request,
                       want.flags.channel_valid, want.flags.channel_select,
                       got.flags.channel_valid, got.flags.channel_select);
              $display("  clr_mute %b/%b unmuted %b/%b setup %b/%b gates %b/%b state %0d/%0d",
                       want.flags.clear_system_mute, got.flags.clear_system_mute,
                       want.flags.mark_unmuted, got.flags.mark_unmuted,
                       want.flags.post_setup, got.flags.post_setup,
                       want.flags.clear_gates, got.flags.clear_gates,
                       want.state_after, got.state_after);
            end
          end
        end
      end
    end
    results_owed <= awaited_results.size();
    mismatch_total <= errors;
  end

endmodule

// ===== test/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import abs_pkg::*;

  localparam logic [CfgIndexWidth-1:0] CFG_SPARE = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     power_on;
  logic                     system_muted;
  logic                     phone_gate;
  logic                     navi_gate;
  logic                     out_valid;
  logic                     out_stall;
  logic                     mute_request;
  logic                     channel_valid;
  logic [1:0]               channel_select;
  logic                     clear_system_mute;
  logic                     mark_unmuted;
  logic                     post_setup;
  logic                     clear_gates;
  logic [2:0]               sequence_state;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [DelayWidth-1:0]    cfg_data;

  int   results_owed;
  int   mismatch_total;
  int   quiet_cycles;
  int   ticks_sent;
  int   settings_loaded;
  logic calm;
  logic hold_req;
  bit   hold_used;

  audio_breakin_sequencer i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .power_on          (power_on),
    .system_muted      (system_muted),
    .phone_gate        (phone_gate),
    .navi_gate         (navi_gate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .mute_request      (mute_request),
    .channel_valid     (channel_valid),
    .channel_select    (channel_select),
    .clear_system_mute (clear_system_mute),
    .mark_unmuted      (mark_unmuted),
    .post_setup        (post_setup),
    .clear_gates       (clear_gates),
    .sequence_state    (sequence_state),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  breakin_monitor i_monitor (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .power_on          (power_on),
    .system_muted      (system_muted),
    .phone_gate        (phone_gate),
    .navi_gate         (navi_gate),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .mute_request      (mute_request),
    .channel_valid     (channel_valid),
    .channel_select    (channel_select),
    .clear_system_mute (clear_system_mute),
    .mark_unmuted      (mark_unmuted),
    .post_setup        (post_setup),
    .clear_gates       (clear_gates),
    .sequence_state    (sequence_state),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .results_owed      (results_owed),
    .mismatch_total    (mismatch_total)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results owed",
                 quiet_cycles, results_owed);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver side, with one long hold-off on request
  initial begin
    out_stall <= 1'b1;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 30);
      end
    end
  end

  task automatic send_tick(input logic pwr, input logic smute, input logic ph, input logic nv);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    power_on <= pwr;
    system_muted <= smute;
    phone_gate <= ph;
    navi_gate <= nv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIndexWidth-1:0] idx, input logic [DelayWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_delays(input abs_cfg_t c, input bit poke_spare);
    logic [DelayWidth-1:0] junk;
    junk = DelayWidth'($urandom);
    drain_results();
    put_reg(CFG_PHONE_ENTRY, c.phone_entry_delay);
    put_reg(CFG_NAVI_ENTRY, c.navi_entry_delay);
    put_reg(CFG_PHONE_SWITCH, c.phone_switch_delay);
    put_reg(CFG_NAVI_SWITCH, c.navi_switch_delay);
    put_reg(CFG_EXIT, c.exit_delay);
    // unused index must leave every delay alone
    if (poke_spare) put_reg(CFG_SPARE, junk);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  function automatic abs_cfg_t random_delays(input int hi);
    abs_cfg_t c;
    c.phone_entry_delay = DelayWidth'($urandom_range(hi));
    c.navi_entry_delay = DelayWidth'($urandom_range(hi));
    c.phone_switch_delay = DelayWidth'($urandom_range(hi));
    c.navi_switch_delay = DelayWidth'($urandom_range(hi));
    c.exit_delay = DelayWidth'($urandom_range(hi));
    return c;
  endfunction

  // gates mostly held for a while so that whole break-in sequences run
  task automatic random_phase(input abs_cfg_t c, input bit poke_spare, input bit hold_off,
                              input int n);
    logic       phone_lvl;
    logic       navi_lvl;
    logic [3:0] f;
    phone_lvl = 1'b0;
    navi_lvl = 1'b0;
    load_delays(c, poke_spare);
    if (hold_off) hold_req <= 1'b1;
    repeat (n) begin
      if ($urandom_range(99) < 6) phone_lvl = ~phone_lvl;
      if ($urandom_range(99) < 6) navi_lvl = ~navi_lvl;
      if ($urandom_range(99) < 10) begin
        f = 4'($urandom_range(15));
      end else begin
        f[3] = ($urandom_range(99) >= 3);
        f[2] = ($urandom_range(99) < 15);
        f[1] = phone_lvl;
        f[0] = navi_lvl;
      end
      send_tick(f[3], f[2], f[1], f[0]);
    end
  endtask

  initial begin
    abs_cfg_t reset_delays;
    reset_delays.phone_entry_delay = PHONE_ENTRY_RESET;
    reset_delays.navi_entry_delay = NAVI_ENTRY_RESET;
    reset_delays.phone_switch_delay = PHONE_SWITCH_RESET;
    reset_delays.navi_switch_delay = NAVI_SWITCH_RESET;
    reset_delays.exit_delay = EXIT_RESET;
    ticks_sent = 0;
    settings_loaded = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    power_on <= 1'b0;
    system_muted <= 1'b0;
    phone_gate <= 1'b0;
    navi_gate <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_PHONE_ENTRY;
    cfg_data <= '0;
    calm <= 1'b0;
    hold_req <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // power off, muted system and no request all stay idle
    send_tick(1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);

    // navigation break-in on the reset delays
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    repeat (NAVI_ENTRY_RESET) send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    repeat (NAVI_SWITCH_RESET) send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0);
    repeat (EXIT_RESET) send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    repeat (EXIT_RESET) send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);

    // request withdrawn in priority, then a wait with nothing serviced
    send_tick(1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);

    // zero delays: phone wins, and a power cut leaves the phone channel flagged
    load_delays('0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1);
    repeat (2) send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    repeat (5) send_tick(1'b1, 1'b0, 1'b0, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0, 1'b0);

    random_phase(reset_delays, 1'b1, 1'b1, 350);
    calm <= 1'b1;
    random_phase(random_delays(3), 1'b0, 1'b0, 250);
    calm <= 1'b0;
    random_phase(random_delays(15), 1'b1, 1'b0, 300);
    random_phase(random_delays(40), 1'b0, 1'b0, 300);
    random_phase('1, 1'b0, 1'b0, 20);

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d ticks sent under %0d delay settings (zero, reset, random, all ones),",
             ticks_sent, settings_loaded);
    $display("with power cuts, muted starts, overlapping gates and a long receiver hold-off");
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_total, results_owed);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/abs_pkg.sv
hw/rtl/abs_step.sv
hw/rtl/audio_breakin_sequencer.sv
test/breakin_monitor.sv
test/testbench.sv
